// File: hdl/fm_step_sequencer_voice_unit_assert.svh
// Assertion macros for the FM step sequencer voice checker.
// Each macro expands to one labelled concurrent assertion with a reset guard.
`ifndef FM_STEP_SEQUENCER_VOICE_UNIT_ASSERT_SVH
`define FM_STEP_SEQUENCER_VOICE_UNIT_ASSERT_SVH

// Same-cycle implication
`define FMSV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmsv check failed");

// Next-cycle implication
`define FMSV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmsv check failed");

`endif

// File: hdl/fmsv_pkg.sv
// Shared types, constants and table functions for the FM step sequencer voice.
// No dependencies.
`timescale 1ns / 1ps

package fmsv_pkg;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 24;
   localparam int SPS_BITS       = 20;
   localparam int RECIP_BITS     = 24;
   localparam logic [SPS_BITS-1:0]   SPS_RESET   = 20'd17640;
   localparam logic [RECIP_BITS-1:0] RECIP_RESET = 24'd97392;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLES_PER_STEP = 1'b0,
      CSR_RATE_RECIPROCAL  = 1'b1
   } csr_index_type;

   // Item codes
   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      FIELD_CARRIER = 2'd0,
      FIELD_MODFREQ = 2'd1,
      FIELD_DEPTH   = 2'd2
   } field_type;

   // Datapath widths
   localparam int VALUE_BITS      = 16;
   localparam int SAMPLE_BITS     = 16;
   localparam int STEP_OUT_BITS   = 3;
   localparam int T_BITS          = 32;
   localparam int T_SHIFT         = 8;
   localparam int MOD_PHASE_BITS  = 28;
   localparam int CAR_PHASE_BITS  = 43;
   localparam int CAR_HI_BITS     = 27;
   localparam int HALF_T_BITS     = 16;
   localparam int FREQ_FRAC_BITS  = 15;
   localparam int FREQ_BITS       = 34;
   localparam int SCALE_SHIFT     = 19;
   // round(2*mag/10) = floor((2*mag + 5) * 52429 / 2^19) for every 16-bit magnitude
   localparam logic [15:0] SCALE_RECIP = 16'd52429;
   localparam logic [4:0]  SCALE_BIAS  = 5'd5;

   localparam logic [VALUE_BITS-1:0] DEPTH_RESET   = 16'd16;
   localparam logic [VALUE_BITS-1:0] MODFREQ_RESET = 16'd0;

   // One step of the sequence, each field unsigned Q12.4
   typedef struct packed {
      logic [VALUE_BITS-1:0] carrier;
      logic [VALUE_BITS-1:0] modfreq;
      logic [VALUE_BITS-1:0] depth;
   } step_entry_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MODPH,
      ST_MODIDX,
      ST_MODROM,
      ST_FREQ,
      ST_CARLO,
      ST_CARHI,
      ST_CARIDX,
      ST_CARROM,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Step contents after reset; the carrier pattern repeats every eight steps
   function automatic step_entry_type step_reset_entry(input logic [2:0] idx);
      step_entry_type e;
      e.modfreq = MODFREQ_RESET;
      e.depth   = DEPTH_RESET;
      case (idx)
         3'd0:    e.carrier = 16'd2093;
         3'd1:    e.carrier = 16'd3520;
         3'd2:    e.carrier = 16'd2093;
         3'd3:    e.carrier = 16'd7040;
         3'd4:    e.carrier = 16'd5280;
         3'd5:    e.carrier = 16'd7040;
         3'd6:    e.carrier = 16'd2093;
         default: e.carrier = 16'd4186;
      endcase
      return e;
   endfunction

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   // Sine of a Q0.32 phase in Q1.15, Taylor series through theta^13 in Q30.
   // Only ever evaluated on constants when the sine ROM is elaborated.
   function automatic logic signed [15:0] sine_from_phase(input logic [31:0] phase);
      logic [1:0]  quad;
      logic [63:0] u;
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] mag;
      longint      sum;
      quad  = phase[31:30];
      u     = {34'd0, phase[29:0]};
      if (quad[0])
         u = Q30_ONE - u;
      theta = (u * HALF_PI_Q30) >> 30;
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      term  = ((term * t2) >> 30) / 64'd6;
      sum   = sum - longint'(term);
      term  = ((term * t2) >> 30) / 64'd20;
      sum   = sum + longint'(term);
      term  = ((term * t2) >> 30) / 64'd42;
      sum   = sum - longint'(term);
      term  = ((term * t2) >> 30) / 64'd72;
      sum   = sum + longint'(term);
      term  = ((term * t2) >> 30) / 64'd110;
      sum   = sum - longint'(term);
      term  = ((term * t2) >> 30) / 64'd156;
      sum   = sum + longint'(term);
      if (sum < 0)
         sum = 0;
      mag = (64'(sum) + 64'd16384) >> 15;
      if (mag > 64'd32767)
         mag = 64'd32767;
      return quad[1] ? $signed(-16'(mag)) : $signed(16'(mag));
   endfunction

endpackage

// File: hdl/fmsv_req_if.sv
// Request channel of the FM step sequencer voice: tick and step-write items.
// Payload widths come from fmsv_pkg.
`timescale 1ns / 1ps

interface fmsv_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [2:0]                       entry_step;
   logic [1:0]                       entry_field;
   logic [fmsv_pkg::VALUE_BITS-1:0]  entry_value;

   modport source(output valid, command, entry_step, entry_field, entry_value,
                  input ready);
   modport sink(input valid, command, entry_step, entry_field, entry_value,
                output ready);
endinterface

// File: hdl/fmsv_rsp_if.sv
// Response channel of the FM step sequencer voice: one sample item per tick.
// Payload widths come from fmsv_pkg.
`timescale 1ns / 1ps

interface fmsv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0]   sample;
   logic [fmsv_pkg::STEP_OUT_BITS-1:0]        step_played;
   logic [fmsv_pkg::STEP_OUT_BITS-1:0]        step_now;

   modport source(output valid, sample, step_played, step_now, input ready);
   modport sink(input valid, sample, step_played, step_now, output ready);
endinterface

// File: hdl/fmsv_sine_rom.sv
// Sine ROM with a registered read port, one Q1.15 value per table entry.
// Contents are built at elaboration by fmsv_pkg::sine_from_phase.
`timescale 1ns / 1ps

module fmsv_sine_rom #(
   parameter int ENTRIES = 1024,
   localparam int IDX_BITS = $clog2(ENTRIES)
) (
   input  logic                                     clock,
   input  logic [IDX_BITS-1:0]                      addr,
   output logic signed [fmsv_pkg::SAMPLE_BITS-1:0]  data
);

   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] rom_data [ENTRIES];
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] q_ff;

   // Entry k holds the sine of phase floor(k * 2^32 / ENTRIES)
   for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
      localparam logic [63:0] PHASE = (64'(k) << 32) / 64'(ENTRIES);
      assign rom_data[k] = fmsv_pkg::sine_from_phase(PHASE[31:0]);
   end

   // Registered read
   always_ff @(posedge clock) begin
      q_ff <= rom_data[addr];
   end

   assign data = q_ff;

endmodule

// File: hdl/fm_step_sequencer_voice_unit.sv
// Eight-step FM voice. A tick item yields one sample item: time is the in-step sample
// count times rate_reciprocal (Q8.24 s), the modulator sine sets the deviation of the
// carrier, and the carrier sine scaled by 0.2 is the sample; the step then advances
// once the count reaches samples_per_step. A write item changes one field of one step
// and yields nothing. A tick goes from FETCH through the modulator and carrier states
// and SCALE to DONE: a chain of dependent multiplies and two reads of the single
// registered sine ROM port. In DONE the sample enters the output register once that is
// free; no item is taken before then. The step table sits in a STEP_COUNT-entry memory
// with one valid bit per entry, so unwritten steps read as their reset values and no
// clearing pass is needed. The block takes one item at a time; a finished sample waits
// in the output register while the next item is taken.
`timescale 1ns / 1ps

module fm_step_sequencer_voice_unit #(
   parameter int STEP_COUNT         = 8,
   parameter int SINE_TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS         = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   fmsv_req_if.sink                              req_chan,
   fmsv_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [fmsv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fmsv_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int STEP_BITS      = $clog2(STEP_COUNT);
   localparam int WIDE_STEP_BITS = (STEP_BITS > 3) ? STEP_BITS : 3;
   localparam int STEP_CMP_BITS  = WIDE_STEP_BITS + 1;
   localparam int IDX_BITS       = $clog2(SINE_TABLE_ENTRIES);
   localparam int ENT_BITS       = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int CMP_BITS       = (COUNT_BITS > fmsv_pkg::SPS_BITS) ?
                                   COUNT_BITS : fmsv_pkg::SPS_BITS;
   localparam int TPROD_BITS     = COUNT_BITS + fmsv_pkg::RECIP_BITS;
   localparam logic [ENT_BITS-1:0]      ENTRIES_K  = ENT_BITS'(SINE_TABLE_ENTRIES);
   localparam logic [STEP_BITS-1:0]     LAST_STEP  = STEP_BITS'(STEP_COUNT - 1);
   localparam logic [STEP_CMP_BITS-1:0] STEP_LIMIT = STEP_CMP_BITS'(STEP_COUNT);
   localparam logic [COUNT_BITS-1:0]    COUNT_ONE  = COUNT_BITS'(1);

   // Control state
   fmsv_pkg::state_type                   state_ff, state_in;
   logic [fmsv_pkg::SPS_BITS-1:0]         sps_ff;
   logic [fmsv_pkg::RECIP_BITS-1:0]       recip_ff;
   logic [COUNT_BITS-1:0]                 count_ff, count_in;
   logic [STEP_BITS-1:0]                  step_ff, step_in;
   logic [STEP_COUNT-1:0]                 valid_ff;
   logic                                  out_valid_ff;

   // Item held while it is worked on
   fmsv_pkg::command_type                 cmd_ff;
   logic [STEP_BITS-1:0]                  addr_ff;
   logic                                  hit_ff;
   logic [1:0]                            field_ff;
   logic [fmsv_pkg::VALUE_BITS-1:0]       value_ff;

   // Step memory and its read port
   fmsv_pkg::step_entry_type              step_mem [STEP_COUNT];
   fmsv_pkg::step_entry_type              rd_q_ff;
   logic                                  rd_valid_ff;

   // Datapath registers
   fmsv_pkg::step_entry_type              entry_ff;
   logic [fmsv_pkg::T_BITS-1:0]           t_ff;
   logic [fmsv_pkg::MOD_PHASE_BITS-1:0]   mphase_ff;
   logic [IDX_BITS-1:0]                   rom_addr_ff;
   logic signed [fmsv_pkg::FREQ_BITS-1:0] freq_ff;
   logic [fmsv_pkg::CAR_PHASE_BITS-1:0]   plo_ff;
   logic [fmsv_pkg::CAR_PHASE_BITS-1:0]   cphase_ff;
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] out_sample_ff;
   logic [fmsv_pkg::STEP_OUT_BITS-1:0]    out_played_ff;
   logic [fmsv_pkg::STEP_OUT_BITS-1:0]    out_now_ff;

   // Combinational signals
   logic                                  req_ready;
   logic                                  req_take;
   logic                                  mem_we;
   logic                                  load_out;
   logic [STEP_CMP_BITS-1:0]              wr_wide;
   logic                                  wr_hit;
   logic [STEP_BITS-1:0]                  wr_addr;
   logic [STEP_BITS-1:0]                  rd_addr;
   logic [WIDE_STEP_BITS-1:0]             addr_wide;
   logic [WIDE_STEP_BITS-1:0]             played_wide;
   logic [WIDE_STEP_BITS-1:0]             now_wide;
   fmsv_pkg::step_entry_type              entry_cur;
   fmsv_pkg::step_entry_type              merged;
   logic                                  field_ok;
   logic [TPROD_BITS-1:0]                 t_prod;
   logic [fmsv_pkg::T_BITS-1:0]           t_next;
   logic [fmsv_pkg::VALUE_BITS+fmsv_pkg::MOD_PHASE_BITS-1:0] mprod;
   logic [fmsv_pkg::MOD_PHASE_BITS+ENT_BITS-1:0] midx_prod;
   logic [fmsv_pkg::CAR_PHASE_BITS+ENT_BITS-1:0] cidx_prod;
   logic [IDX_BITS-1:0]                   rom_addr_in;
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] rom_q;
   logic signed [32:0]                    dev_prod;
   logic signed [fmsv_pkg::FREQ_BITS-1:0] freq_next;
   logic [fmsv_pkg::CAR_PHASE_BITS-1:0]   freq43;
   logic [fmsv_pkg::CAR_PHASE_BITS+fmsv_pkg::HALF_T_BITS-1:0] plo_prod;
   logic [fmsv_pkg::CAR_HI_BITS+fmsv_pkg::HALF_T_BITS-1:0]    phi_prod;
   logic [fmsv_pkg::CAR_PHASE_BITS-1:0]   cphase_next;
   logic                                  cs_neg;
   logic [fmsv_pkg::SAMPLE_BITS-1:0]      cs_mag;
   logic [16:0]                           scale_x;
   logic [32:0]                           scale_prod;
   logic [fmsv_pkg::SAMPLE_BITS-1:0]      scale_q;
   logic signed [fmsv_pkg::SAMPLE_BITS-1:0] sample_next;
   logic                                  advance;

   // Sine ROM shared by the modulator and carrier lookups
   fmsv_sine_rom #(
      .ENTRIES (SINE_TABLE_ENTRIES)
   ) u_sine_rom (
      .clock (clock),
      .addr  (rom_addr_ff),
      .data  (rom_q)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff   <= fmsv_pkg::SPS_RESET;
         recip_ff <= fmsv_pkg::RECIP_RESET;
      end else if (csr_we) begin
         unique case (fmsv_pkg::csr_index_type'(csr_index))
            fmsv_pkg::CSR_SAMPLES_PER_STEP: sps_ff   <= csr_wdata[fmsv_pkg::SPS_BITS-1:0];
            fmsv_pkg::CSR_RATE_RECIPROCAL:  recip_ff <= csr_wdata[fmsv_pkg::RECIP_BITS-1:0];
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fmsv_pkg::ST_IDLE:   if (req_chan.valid) state_in = fmsv_pkg::ST_FETCH;
         fmsv_pkg::ST_FETCH:  state_in = (cmd_ff == fmsv_pkg::CMD_WRITE) ?
                                         fmsv_pkg::ST_IDLE : fmsv_pkg::ST_MODPH;
         fmsv_pkg::ST_MODPH:  state_in = fmsv_pkg::ST_MODIDX;
         fmsv_pkg::ST_MODIDX: state_in = fmsv_pkg::ST_MODROM;
         fmsv_pkg::ST_MODROM: state_in = fmsv_pkg::ST_FREQ;
         fmsv_pkg::ST_FREQ:   state_in = fmsv_pkg::ST_CARLO;
         fmsv_pkg::ST_CARLO:  state_in = fmsv_pkg::ST_CARHI;
         fmsv_pkg::ST_CARHI:  state_in = fmsv_pkg::ST_CARIDX;
         fmsv_pkg::ST_CARIDX: state_in = fmsv_pkg::ST_CARROM;
         fmsv_pkg::ST_CARROM: state_in = fmsv_pkg::ST_SCALE;
         fmsv_pkg::ST_SCALE:  state_in = fmsv_pkg::ST_DONE;
         fmsv_pkg::ST_DONE:   if (!out_valid_ff || rsp_chan.ready) state_in = fmsv_pkg::ST_IDLE;
         default:             state_in = fmsv_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         fmsv_pkg::ST_IDLE:  req_ready = 1'b1;
         fmsv_pkg::ST_FETCH: mem_we    = (cmd_ff == fmsv_pkg::CMD_WRITE) && hit_ff && field_ok;
         fmsv_pkg::ST_DONE:  load_out  = !out_valid_ff || rsp_chan.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = req_ready;
   assign req_take       = req_chan.valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmsv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Write address decode; steps beyond the table are dropped
   assign wr_wide = STEP_CMP_BITS'(req_chan.entry_step);
   assign wr_hit  = wr_wide < STEP_LIMIT;
   assign wr_addr = wr_wide[STEP_BITS-1:0];
   assign rd_addr = (req_chan.command == fmsv_pkg::CMD_WRITE) ? wr_addr : step_ff;

   // Capture the item on acceptance
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= fmsv_pkg::command_type'(req_chan.command);
         addr_ff  <= rd_addr;
         hit_ff   <= (req_chan.command == fmsv_pkg::CMD_WRITE) ? wr_hit : 1'b1;
         field_ff <= req_chan.entry_field;
         value_ff <= req_chan.entry_value;
      end
   end

   // Step memory: read on acceptance, write back in the FETCH state that follows.
   // Items run one at a time, so a write lands before the next read.
   always_ff @(posedge clock) begin
      if (mem_we)
         step_mem[addr_ff] <= merged;
      if (req_take)
         rd_q_ff <= step_mem[rd_addr];
   end

   // Entry valid bits; an invalid entry reads as its reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we)
            valid_ff[addr_ff] <= 1'b1;
         if (req_take)
            rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign addr_wide = WIDE_STEP_BITS'(addr_ff);
   assign entry_cur = rd_valid_ff ? rd_q_ff : fmsv_pkg::step_reset_entry(addr_wide[2:0]);

   // Field merge for a write item
   always_comb begin
      merged   = entry_cur;
      field_ok = 1'b1;
      unique case (fmsv_pkg::field_type'(field_ff))
         fmsv_pkg::FIELD_CARRIER: merged.carrier = value_ff;
         fmsv_pkg::FIELD_MODFREQ: merged.modfreq = value_ff;
         fmsv_pkg::FIELD_DEPTH:   merged.depth   = value_ff;
         default:                 field_ok       = 1'b0;
      endcase
   end

   // Time in Q8.24, then modulator phase and table index
   assign t_prod    = count_ff * recip_ff;
   assign t_next    = fmsv_pkg::T_BITS'(t_prod >> fmsv_pkg::T_SHIFT);
   assign mprod     = entry_ff.modfreq * t_ff[fmsv_pkg::MOD_PHASE_BITS-1:0];
   assign midx_prod = mphase_ff * ENTRIES_K;

   // Instantaneous frequency in Q.19 and carrier phase, split over two products
   assign dev_prod  = rom_q * $signed({1'b0, entry_ff.depth});
   assign freq_next = $signed({3'b000, entry_ff.carrier, {fmsv_pkg::FREQ_FRAC_BITS{1'b0}}})
                      + fmsv_pkg::FREQ_BITS'(dev_prod);
   assign freq43    = fmsv_pkg::CAR_PHASE_BITS'(freq_ff);
   assign plo_prod  = freq43 * t_ff[fmsv_pkg::HALF_T_BITS-1:0];
   assign phi_prod  = freq_ff[fmsv_pkg::CAR_HI_BITS-1:0]
                      * t_ff[fmsv_pkg::T_BITS-1:fmsv_pkg::HALF_T_BITS];
   assign cphase_next = plo_ff + {phi_prod[fmsv_pkg::CAR_HI_BITS-1:0],
                                  {fmsv_pkg::HALF_T_BITS{1'b0}}};
   assign cidx_prod = cphase_ff * ENTRIES_K;

   assign rom_addr_in = (state_ff == fmsv_pkg::ST_MODIDX) ?
      IDX_BITS'(midx_prod >> fmsv_pkg::MOD_PHASE_BITS) :
      IDX_BITS'(cidx_prod >> fmsv_pkg::CAR_PHASE_BITS);

   // Scale by 0.2, rounding halves away from zero
   assign cs_neg      = rom_q[fmsv_pkg::SAMPLE_BITS-1];
   assign cs_mag      = cs_neg ? fmsv_pkg::SAMPLE_BITS'(-rom_q) : rom_q;
   assign scale_x     = {cs_mag, 1'b0} + 17'(fmsv_pkg::SCALE_BIAS);
   assign scale_prod  = scale_x * fmsv_pkg::SCALE_RECIP;
   assign scale_q     = fmsv_pkg::SAMPLE_BITS'(scale_prod >> fmsv_pkg::SCALE_SHIFT);
   assign sample_next = cs_neg ? $signed(-scale_q) : $signed(scale_q);

   // Datapath registers, one multiply per state
   always_ff @(posedge clock) begin
      case (state_ff)
         fmsv_pkg::ST_FETCH: begin
            entry_ff <= entry_cur;
            t_ff     <= t_next;
         end
         fmsv_pkg::ST_MODPH:  mphase_ff   <= fmsv_pkg::MOD_PHASE_BITS'(mprod);
         fmsv_pkg::ST_MODIDX: rom_addr_ff <= rom_addr_in;
         fmsv_pkg::ST_FREQ:   freq_ff     <= freq_next;
         fmsv_pkg::ST_CARLO:  plo_ff      <= fmsv_pkg::CAR_PHASE_BITS'(plo_prod);
         fmsv_pkg::ST_CARHI:  cphase_ff   <= cphase_next;
         fmsv_pkg::ST_CARIDX: rom_addr_ff <= rom_addr_in;
         fmsv_pkg::ST_SCALE:  sample_ff   <= sample_next;
         default: begin
         end
      endcase
   end

   // Step advance once the count reaches samples_per_step
   assign advance  = CMP_BITS'(count_ff) >= CMP_BITS'(sps_ff);
   assign count_in = advance ? COUNT_ONE : count_ff + COUNT_ONE;
   assign step_in  = !advance ? step_ff :
                     (step_ff == LAST_STEP) ? '0 : step_ff + STEP_BITS'(1);
   assign played_wide = WIDE_STEP_BITS'(step_ff);
   assign now_wide    = WIDE_STEP_BITS'(step_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         step_ff  <= '0;
      end else if (load_out) begin
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_sample_ff <= sample_ff;
         out_played_ff <= played_wide[fmsv_pkg::STEP_OUT_BITS-1:0];
         out_now_ff    <= now_wide[fmsv_pkg::STEP_OUT_BITS-1:0];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.sample      = out_sample_ff;
   assign rsp_chan.step_played = out_played_ff;
   assign rsp_chan.step_now    = out_now_ff;

endmodule

// File: hdl/fmsv_checker.sv
// Port-level checks for the FM step sequencer voice, bound to the top level.
// Uses the assertion macros of fm_step_sequencer_voice_unit_assert.svh.
`timescale 1ns / 1ps
`include "fm_step_sequencer_voice_unit_assert.svh"

module fmsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample,
   input logic [2:0]  rsp_step_played,
   input logic [2:0]  rsp_step_now
);

   // One item at a time: busy right after taking one
   `FMSV_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // A fresh sample only appears after the block was busy working on a tick
   `FMSV_ASSERT_IMP(a_result_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // A stalled sample holds
   `FMSV_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample) && $stable(rsp_step_played) && $stable(rsp_step_now))

   // The step either stays, moves on by one, or wraps to the start
   `FMSV_ASSERT_IMP(a_step_move, clock, reset, rsp_valid, (rsp_step_now == rsp_step_played) || (rsp_step_now == rsp_step_played + 3'd1) || (rsp_step_now == 3'd0))

endmodule

bind fm_step_sequencer_voice_unit fmsv_checker u_fmsv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_sample      (rsp_chan.sample),
   .rsp_step_played (rsp_chan.step_played),
   .rsp_step_now    (rsp_chan.step_now)
);
